FILE: hw/rtl/c8w_pkg.sv
`default_nettype none

package c8w_pkg;

  // stream widths
  localparam int IN_W  = 136;
  localparam int OUT_W = 8;

  // result bit positions in m_axis_tdata
  localparam int OB_OVERRIDE = 0;
  localparam int OB_UP       = 1;
  localparam int OB_DOWN     = 2;
  localparam int OB_LEFT     = 3;
  localparam int OB_RIGHT    = 4;
  localparam int OB_HIDDEN   = 5;
  localparam int OB_ENABLED  = 6;
  localparam int OB_DISABLED = 7;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_TOP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_YMIN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CLAMP_YMAX = 3'd4;

  // tan(22.5 deg) as a ratio
  localparam logic [19:0] TAN_NUM = 20'd414214;
  localparam logic [19:0] TAN_DEN = 20'd1000000;

  typedef struct packed {
    logic [9:0]         origin_x;
    logic [9:0]         origin_top;
    logic [15:0]        clamp_x;
    logic signed [16:0] y_floor;
    logic signed [16:0] y_ceil;
  } cfg_t;

  // one classified frame, front to back
  typedef struct packed {
    logic               compute;   // override case, direction still to be worked out
    logic               hidden;
    logic               enabled;
    logic               disabled;
    logic signed [13:0] cursor_x;
    logic signed [13:0] cursor_y;
    logic [12:0]        client_w;
    logic [12:0]        client_h;
    logic signed [16:0] player_x;
    logic signed [16:0] player_y;
    logic [15:0]        step;
  } job_t;

endpackage

`default_nettype wire

FILE: hw/rtl/c8w_front.sv
`default_nettype none

module c8w_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  wire logic [c8w_pkg::IN_W-1:0]   s_axis_tdata_i,
  input  wire logic                       q_ready_i,
  output logic                            q_push_o,
  output c8w_pkg::job_t                   q_job_o
);

  logic        dead_q, dead_d, en_q, en_d, hid_q, hid_d;
  logic        player_ready, toggle, focus;
  logic [12:0] cw, ch;
  logic [11:0] spd;
  logic [15:0] mult;
  logic [27:0] prod;
  logic [15:0] step;
  logic        not43, en_tog, hid_tog, compute;

  assign player_ready = s_axis_tdata_i[0];
  assign toggle       = s_axis_tdata_i[1];
  assign cw           = s_axis_tdata_i[42:30];
  assign ch           = s_axis_tdata_i[55:43];
  assign focus        = s_axis_tdata_i[90];
  assign spd          = focus ? s_axis_tdata_i[114:103] : s_axis_tdata_i[102:91];
  assign mult         = s_axis_tdata_i[130:115];

  // step length, Q4.12 product truncated
  assign prod  = 28'(spd) * 28'(mult);
  assign step  = prod[27:12];
  assign not43 = (15'(cw) * 15'd3) != (15'(ch) * 15'd4);

  assign en_tog  = en_q ^ toggle;
  assign hid_tog = (toggle && !en_tog) ? 1'b0 : hid_q;

  always_comb begin
    dead_d  = dead_q;
    en_d    = en_q;
    hid_d   = hid_q;
    compute = 1'b0;
    if (!dead_q) begin
      en_d  = en_tog;
      hid_d = hid_tog;
      if (en_tog && player_ready && (cw != '0) && (ch != '0)) begin
        if (not43) begin
          dead_d = 1'b1;
          en_d   = 1'b0;
          hid_d  = 1'b0;
        end else if (step != '0) begin
          hid_d   = 1'b1;
          compute = 1'b1;
        end
      end
    end
  end

  assign s_axis_tready_o = q_ready_i;
  assign q_push_o        = s_axis_tvalid_i && q_ready_i;

  always_comb begin
    q_job_o          = '0;
    q_job_o.compute  = compute;
    q_job_o.hidden   = hid_d;
    q_job_o.enabled  = en_d;
    q_job_o.disabled = dead_d;
    q_job_o.cursor_x = s_axis_tdata_i[15:2];
    q_job_o.cursor_y = s_axis_tdata_i[29:16];
    q_job_o.client_w = cw;
    q_job_o.client_h = ch;
    q_job_o.player_x = s_axis_tdata_i[72:56];
    q_job_o.player_y = s_axis_tdata_i[89:73];
    q_job_o.step     = step;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dead_q <= 1'b0;
      en_q   <= 1'b0;
      hid_q  <= 1'b0;
    end else if (q_push_o) begin
      dead_q <= dead_d;
      en_q   <= en_d;
      hid_q  <= hid_d;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/c8w_fifo.sv
`default_nettype none

module c8w_fifo (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire c8w_pkg::job_t job_i,
  output logic               ready_o,
  output logic               valid_o,
  output c8w_pkg::job_t      job_o,
  input  wire logic          pop_i
);

  c8w_pkg::job_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;

  assign ready_o = cnt_q != 2'd2;
  assign valid_o = cnt_q != 2'd0;
  assign job_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/c8w_div.sv
`default_nettype none

// restoring divider, one quotient bit a cycle, truncates toward zero
module c8w_div #(
  parameter int MW = 30
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic signed [MW:0] num_i,
  input  wire logic [12:0]        den_i,
  output logic                    done_o,
  output logic signed [MW:0]      quo_o
);

  localparam int CW = $clog2(MW);

  logic [MW-1:0] acc_q;
  logic [12:0]   rem_q, den_q;
  logic          neg_q, busy_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [MW:0]   mag;
  logic [13:0]   trial, diff;
  logic          ge;

  assign mag   = num_i[MW] ? unsigned'(-num_i) : unsigned'(num_i);
  assign trial = {rem_q, acc_q[MW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= mag[MW-1:0];
      rem_q <= '0;
      den_q <= den_i;
      neg_q <= num_i[MW];
    end else if (busy_q) begin
      acc_q <= {acc_q[MW-2:0], ge};
      rem_q <= ge ? diff[12:0] : trial[12:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CW'(MW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});

endmodule

`default_nettype wire

FILE: hw/rtl/c8w_back.sv
`default_nettype none

module c8w_back #(
  parameter int VIRTUAL_WIDTH  = 640,
  parameter int VIRTUAL_HEIGHT = 480,
  parameter int SUBPIXEL_SCALE = 128
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       job_valid_i,
  input  wire c8w_pkg::job_t              job_i,
  output logic                            job_pop_o,
  input  wire c8w_pkg::cfg_t              cfg_i,
  output logic                            m_axis_tvalid_o,
  input  wire logic                       m_axis_tready_i,
  output logic [c8w_pkg::OUT_W-1:0]       m_axis_tdata_o
);

  localparam int KX   = VIRTUAL_WIDTH * SUBPIXEL_SCALE;
  localparam int KY   = VIRTUAL_HEIGHT * SUBPIXEL_SCALE;
  localparam int KMAX = (KX > KY) ? KX : KY;
  localparam int MW   = 13 + $clog2(KMAX + 1);
  localparam int QW   = MW + 1;
  localparam int OW   = 10 + $clog2(SUBPIXEL_SCALE + 1);
  localparam int TW0  = (QW > OW) ? QW : OW;
  localparam int TW   = ((TW0 > 18) ? TW0 : 18) + 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIVX   = 3'd1;
  localparam logic [2:0] ST_DIVY   = 3'd2;
  localparam logic [2:0] ST_CLAMP  = 3'd3;
  localparam logic [2:0] ST_MUL    = 3'd4;
  localparam logic [2:0] ST_DECIDE = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // multiplier schedule
  localparam logic [2:0] MS_AXX  = 3'd0;
  localparam logic [2:0] MS_AYY  = 3'd1;
  localparam logic [2:0] MS_SS   = 3'd2;
  localparam logic [2:0] MS_AYD  = 3'd3;
  localparam logic [2:0] MS_AXN  = 3'd4;
  localparam logic [2:0] MS_AXD  = 3'd5;
  localparam logic [2:0] MS_AYN  = 3'd6;

  logic [2:0]          state_q, state_d;
  c8w_pkg::job_t       rec_q;
  logic signed [QW-1:0] qx_q, qy_q;
  logic [16:0]         ax_q, ay_q;
  logic                dxpos_q, dypos_q;
  logic [2:0]          step_q;
  logic [36:0]         prod_q [7];
  logic [4:0]          res_q, res_d;
  logic                out_valid_q, out_valid_d;
  logic [7:0]          out_q;

  // divider hookup
  logic                 div_start, div_done;
  logic signed [QW-1:0] cur_ext, kfac, div_num, div_quo;
  logic [12:0]          div_den;

  always_comb begin
    if (state_q == ST_IDLE) begin
      cur_ext = QW'(job_i.cursor_x);
      kfac    = QW'(KX);
      div_den = job_i.client_w;
    end else begin
      cur_ext = QW'(rec_q.cursor_y);
      kfac    = QW'(KY);
      div_den = rec_q.client_h;
    end
    div_num = cur_ext * kfac;
  end

  c8w_div #(.MW(MW)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // offset from origin, then wall clamp
  logic [TW-1:0]        ox_term, oy_term;
  logic signed [TW-1:0] tx, ty, x_lo, x_hi, y_lo, y_hi, txc, tyc;
  logic signed [17:0]   dx, dy;

  assign ox_term = TW'(cfg_i.origin_x) * TW'(SUBPIXEL_SCALE);
  assign oy_term = TW'(cfg_i.origin_top) * TW'(SUBPIXEL_SCALE);
  assign tx      = TW'(qx_q) - $signed(ox_term);
  assign ty      = TW'(qy_q) - $signed(oy_term);
  assign x_hi    = $signed(TW'(cfg_i.clamp_x));
  assign x_lo    = -x_hi;
  assign y_lo    = TW'(cfg_i.y_floor);
  assign y_hi    = TW'(cfg_i.y_ceil);
  assign txc     = (tx < x_lo) ? x_lo : ((tx > x_hi) ? x_hi : tx);
  assign tyc     = (ty < y_lo) ? y_lo : ((ty > y_hi) ? y_hi : ty);
  // clamped targets fit 17 signed bits, so the low 18 bits keep the sign
  assign dx      = txc[17:0] - 18'(rec_q.player_x);
  assign dy      = tyc[17:0] - 18'(rec_q.player_y);

  // shared multiplier
  logic [16:0] mul_a;
  logic [19:0] mul_b;
  logic [36:0] mul_p;

  always_comb begin
    unique case (step_q)
      MS_AXX:  begin mul_a = ax_q;             mul_b = 20'(ax_q);             end
      MS_AYY:  begin mul_a = ay_q;             mul_b = 20'(ay_q);             end
      MS_SS:   begin mul_a = 17'(rec_q.step);  mul_b = 20'(rec_q.step);       end
      MS_AYD:  begin mul_a = ay_q;             mul_b = c8w_pkg::TAN_DEN;      end
      MS_AXN:  begin mul_a = ax_q;             mul_b = c8w_pkg::TAN_NUM;      end
      MS_AXD:  begin mul_a = ax_q;             mul_b = c8w_pkg::TAN_DEN;      end
      MS_AYN:  begin mul_a = ay_q;             mul_b = c8w_pkg::TAN_NUM;      end
      default: begin mul_a = '0;               mul_b = '0;                    end
    endcase
  end

  assign mul_p = 37'(mul_a) * 37'(mul_b);

  // final decision
  logic [37:0] mag2;
  logic        outside, horiz, vert;

  assign mag2    = 38'(prod_q[0]) + 38'(prod_q[1]);
  assign outside = mag2 >= 38'(prod_q[2]);
  assign horiz   = prod_q[3] < prod_q[4];
  assign vert    = prod_q[5] < prod_q[6];

  always_comb begin
    res_d = 5'b00001;
    if (outside) begin
      if (horiz) begin
        res_d[4] = dxpos_q;
        res_d[3] = !dxpos_q;
      end else if (vert) begin
        res_d[2] = dypos_q;
        res_d[1] = !dypos_q;
      end else begin
        res_d[4] = dxpos_q;
        res_d[3] = !dxpos_q;
        res_d[2] = dypos_q;
        res_d[1] = !dypos_q;
      end
    end
  end

  logic out_free;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_comb begin
    state_d     = state_q;
    job_pop_o   = 1'b0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          div_start = job_i.compute;
          state_d   = job_i.compute ? ST_DIVX : ST_OUT;
        end
      end
      ST_DIVX: begin
        if (div_done) begin
          div_start = 1'b1;
          state_d   = ST_DIVY;
        end
      end
      ST_DIVY: begin
        if (div_done) state_d = ST_CLAMP;
      end
      ST_CLAMP: state_d = ST_MUL;
      ST_MUL: begin
        if (step_q == MS_AYN) state_d = ST_DECIDE;
      end
      ST_DECIDE: state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && job_valid_i) begin
      rec_q <= job_i;
      res_q <= '0;
    end
    if (state_q == ST_DIVX && div_done) qx_q <= div_quo;
    if (state_q == ST_DIVY && div_done) qy_q <= div_quo;
    if (state_q == ST_CLAMP) begin
      ax_q    <= dx[17] ? 17'(-dx) : dx[16:0];
      ay_q    <= dy[17] ? 17'(-dy) : dy[16:0];
      dxpos_q <= !dx[17] && (dx != '0);
      dypos_q <= !dy[17] && (dy != '0);
    end
    if (state_q == ST_MUL) prod_q[step_q] <= mul_p;
    if (state_q == ST_DECIDE) res_q <= res_d;
    if (state_q == ST_OUT && out_free) begin
      out_q <= {rec_q.disabled, rec_q.enabled, rec_q.hidden, res_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= MS_AXX;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == ST_MUL) step_q <= step_q + 3'd1;
      else                   step_q <= MS_AXX;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

FILE: hw/rtl/cursor_to_eight_way_direction.sv
// cursor_to_eight_way_direction
// Turns one frame of pointer/player data into eight-way direction presses.
// Input stream (s_axis): one transaction per frame, fields packed in tdata.
// Output stream (m_axis): exactly one result transaction per input frame,
// in order: override, four direction bits and the hidden/enabled/disabled
// flags as they stand after the frame.
// Config channel (cfg_*): register index + data, always ready; write only
// while no frame is in flight.
// A frame that needs no direction (block off, player not ready, odd client,
// zero step) goes from accept through the queue, the back end's idle and
// output states and the output register to m_axis_tvalid. A frame that is
// steered runs two bit-serial divides in one shared divider (MW quotient bits
// each, MW = 13 + clog2(max(W,H)*scale+1), 30 by default), then clamp, seven
// passes through one shared multiplier and a decision. The back end works one
// frame at a time and takes no new frame until the last has left its output
// state; the front takes new frames into a two-deep queue meanwhile.
// Reset clears the enable, disable and hidden flags and loads the default
// config. A stalled m_axis holds its result; the back end stops at its
// output register and the queue fills, then s_axis_tready drops.
`default_nettype none

module cursor_to_eight_way_direction #(
  parameter int VIRTUAL_WIDTH  = 640,
  parameter int VIRTUAL_HEIGHT = 480,
  parameter int SUBPIXEL_SCALE = 128
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // s_axis tdata, low bit up: player_ready, toggle_request, cursor_x[14],
  // cursor_y[14], client_w[13], client_h[13], player_x[17], player_y[17],
  // focus, speed_normal[12], speed_focused[12], speed_mult[16], zero pad[5]
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  input  wire logic [c8w_pkg::IN_W-1:0]          s_axis_tdata_i,
  // m_axis tdata, low bit up: override, dir_up, dir_down, dir_left,
  // dir_right, cursor_hidden, enabled, disabled
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  output logic [c8w_pkg::OUT_W-1:0]              m_axis_tdata_o,
  // config write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [c8w_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [c8w_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // ---------------------------------------------------------------------
  // Config registers
  // ---------------------------------------------------------------------
  c8w_pkg::cfg_t cfg_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x   <= 10'd224;
      cfg_q.origin_top <= 10'd16;
      cfg_q.clamp_x    <= 16'd23552;
      cfg_q.y_floor    <= 17'sd4096;
      cfg_q.y_ceil     <= 17'sd55296;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        c8w_pkg::REG_ORIGIN_X:   cfg_q.origin_x   <= cfg_data_i[9:0];
        c8w_pkg::REG_ORIGIN_TOP: cfg_q.origin_top <= cfg_data_i[9:0];
        c8w_pkg::REG_CLAMP_X:    cfg_q.clamp_x    <= cfg_data_i[15:0];
        c8w_pkg::REG_CLAMP_YMIN: cfg_q.y_floor    <= cfg_data_i;
        c8w_pkg::REG_CLAMP_YMAX: cfg_q.y_ceil     <= cfg_data_i;
        default: ;  // unmapped index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Front: accept, flag update, classification
  // ---------------------------------------------------------------------
  logic          q_ready, q_push, q_valid, q_pop;
  c8w_pkg::job_t q_job_in, q_job_out;

  c8w_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .q_ready_i      (q_ready),
    .q_push_o       (q_push),
    .q_job_o        (q_job_in)
  );

  // two-entry queue between front and back
  c8w_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .job_i  (q_job_in),
    .ready_o(q_ready),
    .valid_o(q_valid),
    .job_o  (q_job_out),
    .pop_i  (q_pop)
  );

  // ---------------------------------------------------------------------
  // Back: divide, clamp, distance and eight-way quantize
  // ---------------------------------------------------------------------
  c8w_back #(
    .VIRTUAL_WIDTH (VIRTUAL_WIDTH),
    .VIRTUAL_HEIGHT(VIRTUAL_HEIGHT),
    .SUBPIXEL_SCALE(SUBPIXEL_SCALE)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (q_valid),
    .job_i          (q_job_out),
    .job_pop_o      (q_pop),
    .cfg_i          (cfg_q),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // no direction without override
  a_dirs_need_override: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tdata_o[c8w_pkg::OB_OVERRIDE]
      |-> m_axis_tdata_o[c8w_pkg::OB_RIGHT:c8w_pkg::OB_UP] == 4'b0000)
    else $error("direction bits set without override");

  // opposite directions never together
  a_no_opposites: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[c8w_pkg::OB_UP] && m_axis_tdata_o[c8w_pkg::OB_DOWN])
      && !(m_axis_tdata_o[c8w_pkg::OB_LEFT] && m_axis_tdata_o[c8w_pkg::OB_RIGHT]))
    else $error("opposite directions pressed");

  // override only while enabled with pointer hidden
  a_override_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[c8w_pkg::OB_OVERRIDE]
      |-> m_axis_tdata_o[c8w_pkg::OB_HIDDEN] && m_axis_tdata_o[c8w_pkg::OB_ENABLED]
        && !m_axis_tdata_o[c8w_pkg::OB_DISABLED])
    else $error("override outside enabled state");

  // disabled block reports off and pointer shown
  a_disabled_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[c8w_pkg::OB_DISABLED]
      |-> !m_axis_tdata_o[c8w_pkg::OB_ENABLED] && !m_axis_tdata_o[c8w_pkg::OB_HIDDEN])
    else $error("disabled block still enabled or hiding pointer");

endmodule

`default_nettype wire
